/* rtl/gsbb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsbb_pkg
// Types and constants for the glyph span bilinear blend unit.
// ---------------------------------------------------------------------------
package gsbb_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_ALPHA = 2'd1;

  localparam logic [15:0] MASK_RB = 16'hF81F;
  localparam logic [15:0] MASK_G = 16'h07E0;
  localparam logic [8:0] ALPHA_FULL = 9'd256;
  localparam logic [5:0] COV_MIN = 6'd8;
  localparam logic [5:0] A_MAX = 6'd63;
  localparam logic [6:0] A_ONE = 7'd64;

  typedef struct packed {
    logic [15:0] dest_pixel;
    logic [7:0] top_left_alpha;
    logic [7:0] top_right_alpha;
    logic [7:0] bottom_left_alpha;
    logic [7:0] bottom_right_alpha;
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    logic right_edge;
    logic last_pixel;
  } in_t;

  typedef struct packed {
    logic [15:0] result_pixel;
    logic end_of_span;
  } out_t;

endpackage

/* rtl/glyph_span_bilinear_blend_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_span_bilinear_blend_unit
// Bilinear glyph coverage, alpha scaling and RGB565 text blend per pixel.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; a beat is taken at every rising
//   edge with start high and busy low. busy is held low, so one pixel can
//   enter on every clock.
//   Output: out_valid strobes for one cycle with out_data; the receiver
//   has no way to stall, so every result must be taken as it appears.
//   Config: cfg_valid/cfg_ready with cfg_index (0 text colour, 1 global
//   alpha) and cfg_data; cfg_ready is always high. Write only while idle.
//   Throughput: one pixel per cycle, set by the six-stage pipeline
//   (horizontal multiply, horizontal add, vertical multiply, vertical add
//   with alpha multiply, weight, blend).
//   Reset (rst_n low, synchronous): pipeline emptied, text colour 0,
//   global alpha 256.
// ---------------------------------------------------------------------------
module glyph_span_bilinear_blend_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  gsbb_pkg::in_t in_data,
  output logic out_valid,
  output gsbb_pkg::out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [gsbb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gsbb_pkg::CfgDataW-1:0] cfg_data
);

  logic [15:0] text_color_r;
  logic [8:0] global_alpha_r;

  // stage valids
  logic [4:0] vld_r;

  // stage 1: horizontal products
  logic signed [25:0] s1_ptop_r, s1_pbot_r;
  logic [7:0] s1_tl_r, s1_bl_r;
  logic [15:0] s1_fy_r, s1_dst_r;
  logic s1_edge_r, s1_last_r;

  // stage 2: row values
  logic [7:0] s2_top_r, s2_bot_r;
  logic [15:0] s2_fy_r, s2_dst_r;
  logic s2_last_r;

  // stage 3: vertical product
  logic signed [25:0] s3_pv_r;
  logic [7:0] s3_top_r;
  logic [15:0] s3_dst_r;
  logic s3_last_r;

  // stage 4: scaled coverage
  logic [16:0] s4_scaled_r;
  logic [15:0] s4_dst_r;
  logic s4_last_r;

  // stage 5: blend weight
  logic [5:0] s5_a_r;
  logic s5_hit_r;
  logic [15:0] s5_dst_r;
  logic s5_last_r;

  logic out_valid_r;
  gsbb_pkg::out_t out_data_r;

  logic accept;
  logic signed [8:0] dtop, dbot, dv;
  logic [9:0] top_sum, bot_sum, v_sum;
  logic [8:0] ga_sat;
  logic [7:0] v_cov;
  logic [5:0] cov;
  logic [6:0] a_raw;
  logic [6:0] a_inv;
  logic [23:0] t_rb, t_g;
  logic [15:0] blended;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= '0;
      global_alpha_r <= gsbb_pkg::ALPHA_FULL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gsbb_pkg::CFG_TEXT_COLOR: text_color_r <= cfg_data;
        gsbb_pkg::CFG_GLOBAL_ALPHA: global_alpha_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[3:0], accept};
      out_valid_r <= vld_r[4];
    end
  end

  always_comb begin
    dtop = $signed({1'b0, in_data.top_right_alpha}) - $signed({1'b0, in_data.top_left_alpha});
    dbot = $signed({1'b0, in_data.bottom_right_alpha})
         - $signed({1'b0, in_data.bottom_left_alpha});
  end

  always_ff @(posedge clk) begin
    s1_ptop_r <= 26'(dtop * $signed({1'b0, in_data.frac_x}));
    s1_pbot_r <= 26'(dbot * $signed({1'b0, in_data.frac_x}));
    s1_tl_r <= in_data.top_left_alpha;
    s1_bl_r <= in_data.bottom_left_alpha;
    s1_fy_r <= in_data.frac_y;
    s1_dst_r <= in_data.dest_pixel;
    s1_edge_r <= in_data.right_edge;
    s1_last_r <= in_data.last_pixel;
  end

  // arithmetic shift gives floor for negative differences
  always_comb begin
    top_sum = 10'($signed({2'b00, s1_tl_r}) + $signed(s1_ptop_r[25:16]));
    bot_sum = 10'($signed({2'b00, s1_bl_r}) + $signed(s1_pbot_r[25:16]));
  end

  always_ff @(posedge clk) begin
    s2_top_r <= s1_edge_r ? s1_tl_r : top_sum[7:0];
    s2_bot_r <= s1_edge_r ? s1_bl_r : bot_sum[7:0];
    s2_fy_r <= s1_fy_r;
    s2_dst_r <= s1_dst_r;
    s2_last_r <= s1_last_r;
  end

  assign dv = $signed({1'b0, s2_bot_r}) - $signed({1'b0, s2_top_r});

  always_ff @(posedge clk) begin
    s3_pv_r <= 26'(dv * $signed({1'b0, s2_fy_r}));
    s3_top_r <= s2_top_r;
    s3_dst_r <= s2_dst_r;
    s3_last_r <= s2_last_r;
  end

  always_comb begin
    v_sum = 10'($signed({2'b00, s3_top_r}) + $signed(s3_pv_r[25:16]));
    v_cov = v_sum[7:0];
    ga_sat = global_alpha_r[8] ? gsbb_pkg::ALPHA_FULL : global_alpha_r;
  end

  always_ff @(posedge clk) begin
    s4_scaled_r <= 17'(v_cov * ga_sat);
    s4_dst_r <= s3_dst_r;
    s4_last_r <= s3_last_r;
  end

  // coverage is at most 63 after the shift
  always_comb begin
    cov = s4_scaled_r[15:10];
    a_raw = 7'({1'b0, cov - gsbb_pkg::COV_MIN} << 1);
  end

  always_ff @(posedge clk) begin
    s5_hit_r <= cov > gsbb_pkg::COV_MIN;
    s5_a_r <= (a_raw > 7'(gsbb_pkg::A_MAX)) ? gsbb_pkg::A_MAX : a_raw[5:0];
    s5_dst_r <= s4_dst_r;
    s5_last_r <= s4_last_r;
  end

  always_comb begin
    a_inv = gsbb_pkg::A_ONE - 7'(s5_a_r);
    t_rb = 24'(s5_dst_r & gsbb_pkg::MASK_RB) * 24'(a_inv)
         + 24'(text_color_r & gsbb_pkg::MASK_RB) * 24'(s5_a_r);
    t_g = 24'(s5_dst_r & gsbb_pkg::MASK_G) * 24'(a_inv)
        + 24'(text_color_r & gsbb_pkg::MASK_G) * 24'(s5_a_r);
    blended = (t_rb[21:6] & gsbb_pkg::MASK_RB) | (t_g[21:6] & gsbb_pkg::MASK_G);
  end

  always_ff @(posedge clk) begin
    out_data_r.result_pixel <= s5_hit_r ? blended : s5_dst_r;
    out_data_r.end_of_span <= s5_last_r;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

/* verif/glyph_span_bilinear_blend_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_span_bilinear_blend_unit_tb
// Self-checking bench for the glyph span blend unit. A queue-fed driver
// sends pixel beats with random gaps. A monitor compares every result
// strobe with a local model of the coverage interpolation, the alpha scale
// and the RGB565 blend. Text colour and global alpha are rewritten between
// phases, only once the pipeline has drained.
// ---------------------------------------------------------------------------
module glyph_span_bilinear_blend_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 84;
  localparam logic [gsbb_pkg::CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [gsbb_pkg::CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  gsbb_pkg::in_t in_data = '0;
  logic out_valid;
  gsbb_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gsbb_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [gsbb_pkg::CfgDataW-1:0] cfg_data = '0;

  gsbb_pkg::in_t pixel_q[$];
  gsbb_pkg::out_t blended_q[$];
  gsbb_pkg::out_t want_px;
  logic [15:0] shadow_text_color = 16'h0000;
  logic [8:0] shadow_global_alpha = gsbb_pkg::ALPHA_FULL;
  int unsigned gap_pct = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  glyph_span_bilinear_blend_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor division by 65536: arithmetic shift of a signed product
  function automatic int lerp_cov(int lo, int hi, int frac);
    return lo + (((hi - lo) * frac) >>> 16);
  endfunction

  function automatic gsbb_pkg::out_t blend_pixel(gsbb_pkg::in_t px);
    int top;
    int bottom;
    int cov;
    int scaled;
    int wt;
    logic [8:0] ga;
    logic [31:0] dst;
    logic [31:0] col;
    logic [31:0] rb;
    logic [31:0] g;
    gsbb_pkg::out_t res;
    top = int'(px.top_left_alpha);
    bottom = int'(px.bottom_left_alpha);
    if (!px.right_edge) begin
      top = lerp_cov(int'(px.top_left_alpha), int'(px.top_right_alpha), int'(px.frac_x));
      bottom = lerp_cov(int'(px.bottom_left_alpha), int'(px.bottom_right_alpha),
                        int'(px.frac_x));
    end
    cov = lerp_cov(top, bottom, int'(px.frac_y));
    ga = (shadow_global_alpha > gsbb_pkg::ALPHA_FULL) ? gsbb_pkg::ALPHA_FULL
                                                       : shadow_global_alpha;
    scaled = (cov * int'(ga)) >> 10;
    res.result_pixel = px.dest_pixel;
    res.end_of_span = px.last_pixel;
    if (scaled > int'(gsbb_pkg::COV_MIN)) begin
      wt = (scaled - int'(gsbb_pkg::COV_MIN)) * 2;
      if (wt > int'(gsbb_pkg::A_MAX)) wt = int'(gsbb_pkg::A_MAX);
      dst = {16'h0000, px.dest_pixel};
      col = {16'h0000, shadow_text_color};
      rb = (dst & gsbb_pkg::MASK_RB) * (gsbb_pkg::A_ONE - wt)
         + (col & gsbb_pkg::MASK_RB) * wt;
      g = (dst & gsbb_pkg::MASK_G) * (gsbb_pkg::A_ONE - wt)
        + (col & gsbb_pkg::MASK_G) * wt;
      res.result_pixel = 16'(((rb >> 6) & gsbb_pkg::MASK_RB) | ((g >> 6) & gsbb_pkg::MASK_G));
    end
    return res;
  endfunction

  function automatic gsbb_pkg::in_t make_pixel(logic [15:0] dest, logic [7:0] tl,
                                               logic [7:0] tr, logic [7:0] bl,
                                               logic [7:0] br, logic [15:0] fx,
                                               logic [15:0] fy, logic rt_edge,
                                               logic last_px);
    gsbb_pkg::in_t px;
    px.dest_pixel = dest;
    px.top_left_alpha = tl;
    px.top_right_alpha = tr;
    px.bottom_left_alpha = bl;
    px.bottom_right_alpha = br;
    px.frac_x = fx;
    px.frac_y = fy;
    px.right_edge = rt_edge;
    px.last_pixel = last_px;
    return px;
  endfunction

  // coverage sample, leaning on the empty and full ends now and then
  function automatic logic [7:0] rand_cov();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender side: hand out queued pixels with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        blended_q.push_back(blend_pixel(in_data));
      end
      if (!start || !busy) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_data <= pixel_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (blended_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %h/%b",
                 $time, out_data.result_pixel, out_data.end_of_span);
        errors++;
      end else begin
        want_px = blended_q.pop_front();
        if (out_data.result_pixel !== want_px.result_pixel) begin
          $display("%0t: result_pixel mismatch, expected %h, got %h",
                   $time, want_px.result_pixel, out_data.result_pixel);
          errors++;
        end
        if (out_data.end_of_span !== want_px.end_of_span) begin
          $display("%0t: end_of_span mismatch, expected %b, got %b",
                   $time, want_px.end_of_span, out_data.end_of_span);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until every queued beat has gone in and every result has come out
  task automatic wait_idle();
    @(posedge clk);
    while (pixel_q.size() != 0 || start || blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gsbb_pkg::CfgIdxW-1:0] idx,
                           input logic [gsbb_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gsbb_pkg::CFG_TEXT_COLOR: shadow_text_color = data;
      gsbb_pkg::CFG_GLOBAL_ALPHA: shadow_global_alpha = data[8:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] colours[RAND_PHASES];
    logic [15:0] alphas[RAND_PHASES];
    colours = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom)};
    alphas = '{16'd256, 16'd1, 16'($urandom), 16'($urandom_range(1, 256)), 16'd511,
               16'($urandom_range(1, 256))};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 36;

    // registers at reset: black text, full opacity
    pixel_q.push_back(make_pixel(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                 1'b1, 1'b1));
    pixel_q.push_back(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                 1'b0, 1'b0));
    // falling row with a tiny fraction rounds down by one
    pixel_q.push_back(make_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'h0001, 16'h0000,
                                 1'b0, 1'b1));
    pixel_q.push_back(make_pixel(16'hAAAA, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h5555, 8'hC8, 8'hC8, 8'h0A, 8'h0A, 16'h8000, 16'h8000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h1234, 8'hFF, 8'h00, 8'h00, 8'hFF, 16'h8000, 16'hFFFF,
                                 1'b1, 1'b1));
    pixel_q.push_back(make_pixel(16'hF81F, 8'h80, 8'h80, 8'h80, 8'h80, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    wait_idle();

    // white text, thresholds around the minimum coverage and the weight clamp
    write_reg(gsbb_pkg::CFG_TEXT_COLOR, 16'hFFFF);
    write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, 16'd256);
    pixel_q.push_back(make_pixel(16'h07E0, 8'h23, 8'h23, 8'h23, 8'h23, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h07E0, 8'h24, 8'h24, 8'h24, 8'h24, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h001F, 8'h28, 8'h28, 8'h28, 8'h28, 16'h0000, 16'h0000,
                                 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(16'h0000, 8'hA0, 8'hA0, 8'hA0, 8'hA0, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h0000, 8'h9C, 8'h9C, 8'h9C, 8'h9C, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    pixel_q.push_back(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h8410, 8'h00, 8'hFF, 8'hFF, 8'h00, 16'h4000, 16'hC000,
                                 1'b0, 1'b1));
    pixel_q.push_back(make_pixel(16'hFFFF, 8'h10, 8'hF0, 8'hF0, 8'h10, 16'hFFFF, 16'h0001,
                                 1'b1, 1'b0));
    wait_idle();

    // zero alpha: every pixel passes through
    write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, 16'd0);
    pixel_q.push_back(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    pixel_q.push_back(make_pixel(16'hABCD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                 1'b1, 1'b0));
    wait_idle();

    // alpha above full scale saturates
    write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, 16'h01FF);
    pixel_q.push_back(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'h1357, 8'h24, 8'h24, 8'h24, 8'h24, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    wait_idle();

    // upper data bits dropped, spare indexes must leave both registers alone
    write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, 16'hFE40);
    write_reg(CFG_SPARE_2, 16'h1234);
    write_reg(CFG_SPARE_3, 16'hFFFF);
    pixel_q.push_back(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                                 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(16'hF800, 8'h90, 8'h90, 8'h90, 8'h90, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    wait_idle();

    write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, 16'd1);
    pixel_q.push_back(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                                 1'b0, 1'b1));
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      gap_pct = (p < 2) ? 36 : ((p < 4) ? 74 : 0);
      write_reg(gsbb_pkg::CFG_TEXT_COLOR, colours[p]);
      write_reg(gsbb_pkg::CFG_GLOBAL_ALPHA, alphas[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase hold-off until the pipeline is empty
        if (p == 3 && n == PHASE_ITEMS / 2) wait_idle();
        pixel_q.push_back(make_pixel(16'($urandom), rand_cov(), rand_cov(), rand_cov(),
                                     rand_cov(), rand_frac(),
                                     ($urandom_range(3) == 0) ? 16'h0000 : rand_frac(),
                                     ($urandom_range(3) == 0),
                                     ($urandom_range(5) == 0)));
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gsbb_pkg.sv
rtl/glyph_span_bilinear_blend_unit.sv
verif/glyph_span_bilinear_blend_unit_tb.sv
